// ----- sv/uas2d_pkg.sv -----
// uas2d_pkg: shared constants, command and status types for the upwind advection stencil
// used by uas2d_ctrl, uas2d_dpath and the top level upwind_advection_stencil_2d_unit
// no dependencies
package uas2d_pkg;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // cell layout and register widths
    localparam int NQ           = 4;
    localparam int DT_BITS      = 31;
    localparam int GW_BITS      = 11;
    localparam int GH_BITS      = 16;
    localparam int CFG_BITS     = 31;
    localparam int CFG_IDX_BITS = 2;
    localparam int CNT_BITS     = 18;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DT_OVER_DX  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DT_OVER_DY  = 2'd3;

    localparam logic [GW_BITS-1:0] GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GH_BITS-1:0] GRID_HEIGHT_RST = 16'd1024;

    // datapath operations
    localparam int OP_BITS = 4;
    typedef logic [OP_BITS-1:0] op_t;

    localparam op_t OP_NONE = 4'd0;
    localparam op_t OP_LOAD = 4'd1;
    localparam op_t OP_RD0  = 4'd2;
    localparam op_t OP_RD1  = 4'd3;
    localparam op_t OP_RD2  = 4'd4;
    localparam op_t OP_DIV  = 4'd5;
    localparam op_t OP_VST  = 4'd6;
    localparam op_t OP_FACE = 4'd7;
    localparam op_t OP_MUL  = 4'd8;
    localparam op_t OP_MST  = 4'd9;
    localparam op_t OP_ACC  = 4'd10;
    localparam op_t OP_OUT  = 4'd11;

    // velocity slots: left, centre x, right, bottom, centre y, top
    localparam logic [2:0] SEL_LAST = 3'd5;

    typedef struct packed {
        op_t        op;
        logic [2:0] sel;
        logic [1:0] qsel;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic div_busy;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- sv/uas2d_div.sv -----
// uas2d_div: bit-serial signed divider giving (num * 2^FRAC_BITS) / den, truncated, saturated
// a zero divisor gives zero; used by uas2d_dpath, needs uas2d_pkg
module uas2d_div #(
    parameter int VALUE_BITS = uas2d_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = uas2d_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] num,
    input  logic signed [VALUE_BITS-1:0] den,
    output logic                         busy,
    output logic                         done,
    output logic signed [VALUE_BITS-1:0] quo
);
    localparam int DW = VALUE_BITS + FRAC_BITS;
    localparam int SW = $clog2(DW + 1);
    localparam logic [DW-1:0] LIM = DW'(1) << (VALUE_BITS - 1);
    localparam logic [SW-1:0] STEP_LAST = SW'(DW - 1);
    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [DW-1:0]         qr_reg, qr_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [SW-1:0]         cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic signed [VALUE_BITS-1:0] quo_reg, quo_next;

    logic [VALUE_BITS-1:0] num_mag, den_mag;
    logic [VALUE_BITS:0]   rem_sh, rem_sub;
    logic                  q_bit;
    logic [DW-1:0]         qr_step;

    assign num_mag = num[VALUE_BITS-1] ? (~num + 1'b1) : num;
    assign den_mag = den[VALUE_BITS-1] ? (~den + 1'b1) : den;

    // one restoring step
    assign rem_sh  = {rem_reg, qr_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign q_bit   = ~rem_sub[VALUE_BITS];
    assign qr_step = {qr_reg[DW-2:0], q_bit};

    always_comb
    begin
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        if (busy_reg)
        begin
            qr_next  = qr_step;
            rem_next = q_bit ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // sign and saturate the magnitude quotient
                if (neg_reg)
                    quo_next = (qr_step > LIM) ? VMIN : -$signed(qr_step[VALUE_BITS-1:0]);
                else
                    quo_next = (qr_step >= LIM) ? VMAX : $signed(qr_step[VALUE_BITS-1:0]);
            end
        end
        else if (start)
        begin
            if (den == '0)
            begin
                quo_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                qr_next   = {num_mag, {FRAC_BITS{1'b0}}};
                rem_next  = '0;
                d_next    = den_mag;
                cnt_next  = '0;
                neg_next  = num[VALUE_BITS-1] ^ den[VALUE_BITS-1];
                busy_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- sv/uas2d_ctrl.sv -----
// uas2d_ctrl: sequencer for one cell: line store access, six divisions, flux and update steps
// drives uas2d_dpath through cmd_t and reads status_t, needs uas2d_pkg
module uas2d_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  uas2d_pkg::status_t status,
    output uas2d_pkg::cmd_t    cmd
);
    import uas2d_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD0  = 4'd1;
    localparam logic [3:0] ST_RD1  = 4'd2;
    localparam logic [3:0] ST_RD2  = 4'd3;
    localparam logic [3:0] ST_DIVS = 4'd4;
    localparam logic [3:0] ST_DIVW = 4'd5;
    localparam logic [3:0] ST_FACE = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_MST  = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    localparam logic [1:0] Q_LAST = 2'(NQ - 1);

    logic [3:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [2:0] m_reg, m_next;
    logic [1:0] q_reg, q_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        q_next     = q_reg;
        s_tready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.sel    = 3'd0;
        cmd.qsel   = q_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                cmd.op     = OP_RD0;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.op     = OP_RD1;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.op     = OP_RD2;
                k_next     = 3'd0;
                state_next = status.emit ? ST_DIVS : ST_IDLE;
            end
            ST_DIVS:
            begin
                cmd.op     = OP_DIV;
                cmd.sel    = k_reg;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                cmd.sel = k_reg;
                if (status.div_done)
                begin
                    cmd.op = OP_VST;
                    if (k_reg == SEL_LAST)
                        state_next = ST_FACE;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_FACE:
            begin
                cmd.op     = OP_FACE;
                m_next     = 3'd0;
                q_next     = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.sel    = m_reg;
                state_next = ST_MST;
            end
            ST_MST:
            begin
                cmd.op  = OP_MST;
                cmd.sel = m_reg;
                if (m_reg == SEL_LAST)
                    state_next = ST_ACC;
                else
                begin
                    m_next     = m_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                m_next = 3'd0;
                if (q_reg == Q_LAST)
                    state_next = ST_OUT;
                else
                begin
                    q_next     = q_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            m_reg     <= '0;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            q_reg     <= q_next;
        end
    end

endmodule

// ----- sv/uas2d_dpath.sv -----
// uas2d_dpath: config registers, counters, line store, window, divider, multiplier, output beat
// driven by uas2d_ctrl via cmd_t, instantiates uas2d_div, needs uas2d_pkg
module uas2d_dpath #(
    parameter int MAX_WIDTH  = uas2d_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = uas2d_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = uas2d_pkg::FRAC_BITS_DEF,
    parameter int TDW        = ((uas2d_pkg::NQ * VALUE_BITS + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [uas2d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [uas2d_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic [TDW-1:0]                       s_tdata,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [TDW-1:0]                       m_tdata,
    output logic                                 m_tlast,
    input  uas2d_pkg::cmd_t                      cmd,
    output uas2d_pkg::status_t                   status
);
    import uas2d_pkg::*;

    localparam int VB  = VALUE_BITS;
    localparam int IW  = NQ * VB;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int AW  = CW + 1;
    localparam int MW  = (VB + 1 > DT_BITS + 1) ? VB + 1 : DT_BITS + 1;
    localparam int PW  = 2 * MW;
    localparam int XW  = PW + 2;
    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic [CNT_BITS-1:0] W_MIN = CNT_BITS'(3);
    localparam logic [CNT_BITS-1:0] W_MAX = CNT_BITS'(MAX_WIDTH);

    function automatic logic signed [VB-1:0] sat_p(input logic signed [PW-1:0] x);
        logic signed [VB-1:0] y;
        if (x > PW'(VMAX))
            y = VMAX;
        else if (x < PW'(VMIN))
            y = VMIN;
        else
            y = x[VB-1:0];
        return y;
    endfunction

    function automatic logic signed [VB-1:0] sat_x(input logic signed [XW-1:0] x);
        logic signed [VB-1:0] y;
        if (x > XW'(VMAX))
            y = VMAX;
        else if (x < XW'(VMIN))
            y = VMIN;
        else
            y = x[VB-1:0];
        return y;
    endfunction

    // configuration
    logic [GW_BITS-1:0] gw_reg;
    logic [GH_BITS-1:0] gh_reg;
    logic [DT_BITS-1:0] dtx_reg, dty_reg;

    // frame position
    logic [CW-1:0]      col_reg;
    logic [GH_BITS-1:0] row_reg;
    logic [CNT_BITS-1:0] w_eff, h_eff, col_ext, row_ext, col_inc, row_inc;

    // captured cell
    logic [IW-1:0] cell_reg;
    logic [CW-1:0] ccol_reg;
    logic          bank_reg, emit_reg, last_reg;

    // line store
    logic [IW-1:0] mem [2**AW];
    logic [IW-1:0] rda_reg, rdb_reg;
    logic [AW-1:0] addr_a, addr_b;

    // window and arithmetic state
    logic [IW-1:0]          win_reg [5];
    logic signed [VB-1:0]   wf [5][NQ];
    logic signed [VB-1:0]   dq [5];
    logic signed [VB-1:0]   vel_reg [6];
    logic signed [VB-1:0]   face_reg [4];
    logic signed [VB-1:0]   flux_reg [4];
    logic signed [PW-1:0]   tx_reg, ty_reg, prod_reg, prod_sh;
    logic signed [VB-1:0]   res_reg [NQ];
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [XW-1:0]   acc;
    logic signed [VB:0]     sum_l, sum_r, sum_b, sum_t;

    // divider hookup
    logic signed [VB-1:0] div_num, div_den, div_quo;
    logic                 div_busy, div_done;

    // output beat
    logic           m_valid_reg;
    logic [TDW-1:0] m_data_reg, out_pack;
    logic           m_last_reg;

    // config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= GRID_WIDTH_RST;
            gh_reg  <= GRID_HEIGHT_RST;
            dtx_reg <= '0;
            dty_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  gw_reg  <= cfg_data[GW_BITS-1:0];
                REG_GRID_HEIGHT: gh_reg  <= cfg_data[GH_BITS-1:0];
                REG_DT_OVER_DX:  dtx_reg <= cfg_data[DT_BITS-1:0];
                REG_DT_OVER_DY:  dty_reg <= cfg_data[DT_BITS-1:0];
                default:         gw_reg  <= gw_reg;
            endcase
        end
    end

    // clamped geometry and counter arithmetic
    always_comb
    begin
        w_eff = CNT_BITS'(gw_reg);
        if (w_eff < W_MIN)
            w_eff = W_MIN;
        else if (w_eff > W_MAX)
            w_eff = W_MAX;
        h_eff = CNT_BITS'(gh_reg);
        if (h_eff < W_MIN)
            h_eff = W_MIN;
        col_ext = CNT_BITS'(col_reg);
        row_ext = CNT_BITS'(row_reg);
        col_inc = col_ext + 1'b1;
        row_inc = row_ext + 1'b1;
    end

    // counters, cell capture and halo decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            emit_reg <= 1'b0;
            last_reg <= 1'b0;
            bank_reg <= 1'b0;
            ccol_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            bank_reg <= row_reg[0];
            ccol_reg <= col_reg;
            emit_reg <= (row_ext >= CNT_BITS'(2)) && (row_ext < h_eff) &&
                        (col_ext >= CNT_BITS'(1)) && (col_ext + CNT_BITS'(2) <= w_eff);
            last_reg <= (row_inc == h_eff) && (col_ext + CNT_BITS'(2) == w_eff);
            if (col_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (row_inc >= h_eff) ? '0 : row_inc[GH_BITS-1:0];
            end
            else
                col_reg <= col_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            cell_reg <= s_tdata[IW-1:0];
    end

    // line store addresses: previous row bank is the other bank
    always_comb
    begin
        if (cmd.op == OP_RD0)
        begin
            addr_a = {~bank_reg, ccol_reg - 1'b1};
            addr_b = {bank_reg, ccol_reg};
        end
        else
        begin
            addr_a = {~bank_reg, ccol_reg};
            addr_b = {~bank_reg, ccol_reg + 1'b1};
        end
    end

    // line store: read before write, two read ports
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RD0 || cmd.op == OP_RD1)
        begin
            rda_reg <= mem[addr_a];
            rdb_reg <= mem[addr_b];
        end
        if (cmd.op == OP_RD0)
            mem[{bank_reg, ccol_reg}] <= cell_reg;
    end

    // five-point window
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RD1)
        begin
            win_reg[0] <= rda_reg;
            win_reg[3] <= rdb_reg;
        end
        if (cmd.op == OP_RD2)
        begin
            win_reg[1] <= rda_reg;
            win_reg[2] <= rdb_reg;
            win_reg[4] <= cell_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            for (int q = 0; q < NQ; q++)
                wf[i][q] = win_reg[i][q*VB +: VB];
            dq[i] = wf[i][cmd.qsel];
        end
    end

    // divider operands: density and momentum of the selected cell
    always_comb
    begin
        case (cmd.sel)
            3'd0:    begin div_den = wf[0][0]; div_num = wf[0][1]; end
            3'd1:    begin div_den = wf[1][0]; div_num = wf[1][1]; end
            3'd2:    begin div_den = wf[2][0]; div_num = wf[2][1]; end
            3'd3:    begin div_den = wf[3][0]; div_num = wf[3][2]; end
            3'd4:    begin div_den = wf[1][0]; div_num = wf[1][2]; end
            default: begin div_den = wf[4][0]; div_num = wf[4][2]; end
        endcase
    end

    uas2d_div #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // face velocities as floored means
    assign sum_l = (VB+1)'(vel_reg[0]) + (VB+1)'(vel_reg[1]);
    assign sum_r = (VB+1)'(vel_reg[2]) + (VB+1)'(vel_reg[1]);
    assign sum_b = (VB+1)'(vel_reg[3]) + (VB+1)'(vel_reg[4]);
    assign sum_t = (VB+1)'(vel_reg[5]) + (VB+1)'(vel_reg[4]);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_VST)
            vel_reg[cmd.sel] <= div_quo;
        if (cmd.op == OP_FACE)
        begin
            face_reg[0] <= VB'(sum_l >>> 1);
            face_reg[1] <= VB'(sum_r >>> 1);
            face_reg[2] <= VB'(sum_b >>> 1);
            face_reg[3] <= VB'(sum_t >>> 1);
        end
    end

    // multiplier operands: upwind fluxes, then the two scaled differences
    always_comb
    begin
        case (cmd.sel)
            3'd0:
            begin
                mul_a = MW'(face_reg[0]);
                mul_b = MW'((face_reg[0] > 0) ? dq[0] : dq[1]);
            end
            3'd1:
            begin
                mul_a = MW'(face_reg[1]);
                mul_b = MW'((face_reg[1] < 0) ? dq[2] : dq[1]);
            end
            3'd2:
            begin
                mul_a = MW'(face_reg[2]);
                mul_b = MW'((face_reg[2] > 0) ? dq[3] : dq[1]);
            end
            3'd3:
            begin
                mul_a = MW'(face_reg[3]);
                mul_b = MW'((face_reg[3] < 0) ? dq[4] : dq[1]);
            end
            3'd4:
            begin
                mul_a = $signed({{(MW-DT_BITS){1'b0}}, dtx_reg});
                mul_b = MW'(flux_reg[1]) - MW'(flux_reg[0]);
            end
            default:
            begin
                mul_a = $signed({{(MW-DT_BITS){1'b0}}, dty_reg});
                mul_b = MW'(flux_reg[3]) - MW'(flux_reg[2]);
            end
        endcase
    end

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign acc = XW'(dq[1]) - XW'(tx_reg) - XW'(ty_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MUL)
            prod_reg <= mul_a * mul_b;
        if (cmd.op == OP_MST)
        begin
            case (cmd.sel)
                3'd4:    tx_reg <= prod_sh;
                3'd5:    ty_reg <= prod_sh;
                default: flux_reg[cmd.sel[1:0]] <= sat_p(prod_sh);
            endcase
        end
        if (cmd.op == OP_ACC)
            res_reg[cmd.qsel] <= sat_x(acc);
    end

    // output register
    always_comb
    begin
        out_pack = '0;
        for (int q = 0; q < NQ; q++)
            out_pack[q*VB +: VB] = res_reg[q];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            m_data_reg <= out_pack;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign status.emit     = emit_reg;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_free = ~m_valid_reg | m_tready;

endmodule

// ----- sv/upwind_advection_stencil_2d_unit.sv -----
// upwind_advection_stencil_2d_unit: top level of the donor-cell upwind advection stencil
// instantiates uas2d_ctrl and uas2d_dpath, needs uas2d_pkg
//
// Cells arrive in raster order, halo included, one beat per cell on s_*; one beat leaves on m_*
// for each interior centre (the cell one row above the arriving one), m_tlast on the frame's
// last interior cell. One cell is worked at a time. A halo cell goes through the accept and three
// line store steps only. An interior cell goes on through six velocity divisions, the face step,
// the flux update and the output beat, and waits longer while the previous beat still waits on
// m_tready: the six velocity divisions go one after another through a single bit-serial divider
// that retires one quotient bit per cycle (a zero divisor skips the bit steps), and the 24 products
// of the flux update share one registered multiplier, plus one accumulate step per quantity.
// The next cell is taken while a finished beat still waits on m_tready.
module upwind_advection_stencil_2d_unit #(
    parameter int MAX_WIDTH  = uas2d_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = uas2d_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = uas2d_pkg::FRAC_BITS_DEF,
    localparam int TDW       = ((uas2d_pkg::NQ * VALUE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // density, momentum_x, momentum_y, energy
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDW-1:0]                     s_tdata,
    // new_density, new_momentum_x, new_momentum_y, new_energy
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDW-1:0]                     m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [uas2d_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [uas2d_pkg::CFG_BITS-1:0]     cfg_data
);
    import uas2d_pkg::*;

    cmd_t    cmd;
    status_t status;

    uas2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    uas2d_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TDW        (TDW)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // one cell in flight: no beat taken right after another
    a_single_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input beat accepted while a cell is in flight");

    // divider is only started when idle
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV) |-> !status.div_busy)
        else $error("divider started while busy");

    // a result never overwrites a beat still waiting
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!m_tvalid || m_tready))
        else $error("output beat overwritten");

endmodule
